>>> hdl/cpd_pkg.sv
// shared constants and types for the crc-32 packet deframer
// no dependencies; imported by cpd_crc_byte, crc32_packet_deframer and the bench
`default_nettype none

package cpd_pkg;

    // checksum trailer length in bytes, sent least significant byte first
    localparam int CRC_BYTES = 4;

    // reflected crc-32
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // parser phase codes
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_TYPE = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_PAY  = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;

    // byte role codes on the result channel
    localparam logic [2:0] ROLE_IDLE     = 3'd0;
    localparam logic [2:0] ROLE_START    = 3'd1;
    localparam logic [2:0] ROLE_TYPE     = 3'd2;
    localparam logic [2:0] ROLE_LENGTH   = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD  = 3'd4;
    localparam logic [2:0] ROLE_CHECKSUM = 3'd5;

    localparam logic [7:0] START_BYTE_RESET = 8'hAA;

    typedef logic [31:0] crc_t;

endpackage

`default_nettype wire

>>> hdl/crc32_packet_deframer.sv
// top level of the start / type / length / payload / crc-32 frame parser
// depends on cpd_pkg and cpd_crc_byte
`default_nettype none

// usage
//   in channel   : in_valid / in_ready / rx_byte, one received byte per beat
//   out channel  : out_valid / out_ready and the result fields, exactly one
//                  result beat for every input beat, in order
//   cfg channel  : cfg_valid / cfg_ready / cfg_data writes the start byte;
//                  cfg_ready is always high, write only while the block is idle
//   result       : registered, shown in the cycle after its input beat is taken
//   throughput   : one byte per cycle while results drain; the parser state, the
//                  byte-wide crc update and the trailer compare are all
//                  combinational between the accepted beat and the result register
//   stall        : while a result waits with out_ready low, in_ready drops;
//                  in_ready is high whenever the result register is empty or
//                  is being drained in the same cycle
//   reset        : rst_n low clears the result valid flag, returns the parser to
//                  hunting for the start byte and loads the start byte 0xaa
//   bad frames   : payload is streamed, not buffered; a frame always ends with
//                  packet_done, and packet_ok tells whether the crc matched

module crc32_packet_deframer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    // received bytes
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    // results
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      byte_role,
    output logic [7:0]      data_byte,
    output logic [7:0]      payload_index,
    output logic [7:0]      msg_type,
    output logic [7:0]      msg_length,
    output logic            packet_done,
    output logic            packet_ok
);
    import cpd_pkg::*;

    // parser state
    logic [7:0]  start_byte_reg;
    logic [2:0]  phase_reg,   phase_next;
    logic [7:0]  count_reg,   count_next;
    crc_t        crc_reg,     crc_next;
    logic [7:0]  type_reg,    type_next;
    logic [7:0]  length_reg,  length_next;
    logic [23:0] rx_crc_reg,  rx_crc_next;

    // result register
    logic        out_valid_reg;
    logic [2:0]  role_reg,    role_next;
    logic [7:0]  data_reg;
    logic [7:0]  pidx_reg,    pidx_next;
    logic [7:0]  mtype_reg,   mtype_next;
    logic [7:0]  mlen_reg,    mlen_next;
    logic        done_reg,    done_next;
    logic        ok_reg,      ok_next;

    logic        in_beat;
    crc_t        crc_fed;
    logic [7:0]  count_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;
    assign count_inc = count_reg + 8'd1;

    cpd_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data    (rx_byte),
        .crc_out (crc_fed)
    );

    // one pass of the parser per accepted byte
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        type_next   = type_reg;
        length_next = length_reg;
        rx_crc_next = rx_crc_reg;
        role_next   = ROLE_IDLE;
        pidx_next   = 8'd0;
        mtype_next  = 8'd0;
        mlen_next   = 8'd0;
        done_next   = 1'b0;
        ok_next     = 1'b0;

        unique case (phase_reg)
            PH_TYPE:
            begin
                role_next  = ROLE_TYPE;
                type_next  = rx_byte;
                crc_next   = crc_fed;
                mtype_next = rx_byte;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                role_next   = ROLE_LENGTH;
                length_next = rx_byte;
                crc_next    = crc_fed;
                mtype_next  = type_reg;
                mlen_next   = rx_byte;
                count_next  = 8'd0;
                rx_crc_next = 24'd0;
                // zero length goes straight to the trailer
                phase_next  = (rx_byte != 8'd0) ? PH_PAY : PH_CRC;
            end
            PH_PAY:
            begin
                role_next  = ROLE_PAYLOAD;
                pidx_next  = count_reg;
                crc_next   = crc_fed;
                mtype_next = type_reg;
                mlen_next  = length_reg;
                count_next = count_inc;
                if (count_inc == 8'd0 || count_inc >= length_reg)
                begin
                    count_next = 8'd0;
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                role_next  = ROLE_CHECKSUM;
                mtype_next = type_reg;
                mlen_next  = length_reg;
                if (count_reg >= 8'(CRC_BYTES - 1))
                begin
                    // last trailer byte closes the frame
                    done_next   = 1'b1;
                    ok_next     = ({rx_byte, rx_crc_reg} == crc_reg);
                    phase_next  = PH_HUNT;
                    count_next  = 8'd0;
                    rx_crc_next = 24'd0;
                end
                else
                begin
                    unique case (count_reg[1:0])
                        2'd0:    rx_crc_next[7:0]   = rx_byte;
                        2'd1:    rx_crc_next[15:8]  = rx_byte;
                        default: rx_crc_next[23:16] = rx_byte;
                    endcase
                    count_next = count_inc;
                end
            end
            default:
            begin
                // hunting; unused phase codes land here too
                phase_next = PH_HUNT;
                if (rx_byte == start_byte_reg)
                begin
                    role_next   = ROLE_START;
                    crc_next    = CRC_INIT;
                    type_next   = 8'd0;
                    length_next = 8'd0;
                    count_next  = 8'd0;
                    rx_crc_next = 24'd0;
                    phase_next  = PH_TYPE;
                end
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
            phase_reg      <= PH_HUNT;
            count_reg      <= 8'd0;
            crc_reg        <= CRC_INIT;
            type_reg       <= 8'd0;
            length_reg     <= 8'd0;
            rx_crc_reg     <= 24'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                start_byte_reg <= cfg_data;
            end
            if (in_beat)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                crc_reg    <= crc_next;
                type_reg   <= type_next;
                length_reg <= length_next;
                rx_crc_reg <= rx_crc_next;
            end
            if (in_beat)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            role_reg  <= role_next;
            data_reg  <= rx_byte;
            pidx_reg  <= pidx_next;
            mtype_reg <= mtype_next;
            mlen_reg  <= mlen_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_role     = role_reg;
    assign data_byte     = data_reg;
    assign payload_index = pidx_reg;
    assign msg_type      = mtype_reg;
    assign msg_length    = mlen_reg;
    assign packet_done   = done_reg;
    assign packet_ok     = ok_reg;

endmodule

`default_nettype wire

>>> hdl/cpd_crc_byte.sv
// byte-wide reflected crc-32 update, eight bit steps unrolled
// depends on cpd_pkg
`default_nettype none

module cpd_crc_byte (
    input  wire cpd_pkg::crc_t crc_in,
    input  wire logic [7:0]    data,
    output cpd_pkg::crc_t      crc_out
);
    import cpd_pkg::*;

    always_comb
    begin
        crc_t c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

>>> bench/tb.sv
// self-checking bench for crc32_packet_deframer: framed and noisy byte streams
// with random stalls, checked beat by beat against a built-in frame parser model
// depends on cpd_pkg and the deframer rtl
`timescale 1ns / 1ps

module tb;
    import cpd_pkg::*;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int RANDOM_BYTES  = 750;
    localparam int NUM_SETTINGS  = 6;
    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 8;

    // one result beat as the deframer should present it
    typedef struct packed {
        logic [2:0] role;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] mtype;
        logic [7:0] mlen;
        logic       done;
        logic       ok;
    } result_t;

    // running model of the frame parser plus the queue of results it owes
    class deframe_scoreboard;
        logic [7:0]  start_value;
        logic [2:0]  phase;
        logic [7:0]  count;
        crc_t        crc;
        logic [7:0]  ftype;
        logic [7:0]  flen;
        logic [23:0] crc_low;
        result_t     owed_q[$];
        int          errors;
        int          checked;
        int          frames_good;
        int          frames_bad;

        function new();
            start_value = START_BYTE_RESET;
            phase       = PH_HUNT;
            count       = '0;
            crc         = CRC_INIT;
            ftype       = '0;
            flen        = '0;
            crc_low     = '0;
            errors      = 0;
            checked     = 0;
            frames_good = 0;
            frames_bad  = 0;
        endfunction

        static function crc_t crc_step(crc_t c, logic [7:0] b);
            crc_t r;
            r = c ^ {24'h0, b};
            for (int i = 0; i < 8; i++)
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function void set_start(logic [7:0] v);
            start_value = v;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // advance the parser by one accepted byte and queue the result it owes
        function void note_byte(logic [7:0] b);
            result_t     r;
            logic [31:0] rx_crc;
            r      = '0;
            r.data = b;
            case (phase)
                PH_TYPE: begin
                    r.role  = ROLE_TYPE;
                    ftype   = b;
                    crc     = crc_step(crc, b);
                    r.mtype = ftype;
                    phase   = PH_LEN;
                end
                PH_LEN: begin
                    r.role  = ROLE_LENGTH;
                    flen    = b;
                    crc     = crc_step(crc, b);
                    r.mtype = ftype;
                    r.mlen  = flen;
                    count   = '0;
                    crc_low = '0;
                    phase   = (b != 8'd0) ? PH_PAY : PH_CRC;
                end
                PH_PAY: begin
                    r.role  = ROLE_PAYLOAD;
                    r.index = count;
                    crc     = crc_step(crc, b);
                    r.mtype = ftype;
                    r.mlen  = flen;
                    count   = count + 8'd1;
                    if (count == 8'd0 || count >= flen) begin
                        count = '0;
                        phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    r.role  = ROLE_CHECKSUM;
                    r.mtype = ftype;
                    r.mlen  = flen;
                    if (count >= CRC_BYTES - 1) begin
                        rx_crc  = {b, crc_low};
                        r.done  = 1'b1;
                        r.ok    = (rx_crc == crc);
                        if (r.ok)
                            frames_good++;
                        else
                            frames_bad++;
                        phase   = PH_HUNT;
                        count   = '0;
                        crc_low = '0;
                    end else begin
                        crc_low = crc_low | (24'(b) << (8 * count));
                        count   = count + 8'd1;
                    end
                end
                default: begin
                    phase = PH_HUNT;
                    if (b == start_value) begin
                        r.role  = ROLE_START;
                        crc     = CRC_INIT;
                        ftype   = '0;
                        flen    = '0;
                        count   = '0;
                        crc_low = '0;
                        phase   = PH_TYPE;
                    end
                end
            endcase
            owed_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, got %0h", $time, got);
                return;
            end
            want = owed_q.pop_front();
            checked++;
            compare_field("byte_role", 8'(want.role), 8'(got.role));
            compare_field("data_byte", want.data, got.data);
            compare_field("payload_index", want.index, got.index);
            compare_field("msg_type", want.mtype, got.mtype);
            compare_field("msg_length", want.mlen, got.mlen);
            compare_field("packet_done", 8'(want.done), 8'(got.done));
            compare_field("packet_ok", 8'(want.ok), 8'(got.ok));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] byte_role;
    logic [7:0] data_byte;
    logic [7:0] payload_index;
    logic [7:0] msg_type;
    logic [7:0] msg_length;
    logic       packet_done;
    logic       packet_ok;

    deframe_scoreboard sb;

    // handshake between the stimulus and the receiver process
    bit hold_req;
    bit tx_steady;
    bit rx_steady;

    int         cycle_count = 0;
    int         bytes_sent;
    int         settings_used;
    logic [7:0] start_now;
    logic [7:0] frame_bytes[$];

    crc32_packet_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_role     (byte_role),
        .data_byte     (data_byte),
        .payload_index (payload_index),
        .msg_type      (msg_type),
        .msg_length    (msg_length),
        .packet_done   (packet_done),
        .packet_ok     (packet_ok)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog, sized well beyond the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // monitor: sampled at the edge, so all values are the pre-edge ones
    // the input beat is noted before the result is checked, in case the two coincide
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.set_start(cfg_data);
            if (in_valid && in_ready)
                sb.note_byte(rx_byte);
            if (out_valid && out_ready)
                sb.check_result('{byte_role, data_byte, payload_index, msg_type,
                                  msg_length, packet_done, packet_ok});
        end
    end

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 94)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // receiver: random ready pattern, a steady mode, and the long hold-off on request
    initial
    begin : receiver
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (rx_steady) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else if ($urandom_range(0, 99) < 60) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    // one beat on the byte channel; valid stays up into the next call unless a gap follows
    task automatic send_byte(input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_queue();
        while (frame_bytes.size() != 0)
            send_byte(frame_bytes.pop_front());
    endtask

    // stop offering bytes and wait until every owed result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_start(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        start_now = v;
        settings_used++;
    endtask

    // append a whole frame; fill_en gives a constant payload, bad flips one trailer bit
    task automatic push_frame(input logic [7:0] sbyte, input logic [7:0] typ, input int len,
                              input bit fill_en, input logic [7:0] fill, input bit bad);
        crc_t       c;
        logic [7:0] b;
        logic [7:0] trailer[4];
        c = CRC_INIT;
        frame_bytes.push_back(sbyte);
        frame_bytes.push_back(typ);
        frame_bytes.push_back(8'(len));
        c = deframe_scoreboard::crc_step(c, typ);
        c = deframe_scoreboard::crc_step(c, 8'(len));
        for (int i = 0; i < len; i++) begin
            b = fill_en ? fill : 8'($urandom);
            c = deframe_scoreboard::crc_step(c, b);
            frame_bytes.push_back(b);
        end
        // checksum trailer goes out least significant byte first
        for (int k = 0; k < 4; k++)
            trailer[k] = c[8*k +: 8];
        if (bad)
            trailer[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        for (int k = 0; k < 4; k++)
            frame_bytes.push_back(trailer[k]);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 8);
        else if (r < 98)
            return $urandom_range(9, 40);
        else
            return $urandom_range(41, 100);
    endfunction

    // one random slice of traffic: mostly clean frames, some noise and cut-off frames
    task automatic random_chunk();
        int r;
        int keep;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            push_frame(start_now, 8'($urandom), pick_len(), 1'b0, 8'h00,
                       $urandom_range(0, 99) < 15);
        end else if (r < 85) begin
            repeat ($urandom_range(1, 6))
                frame_bytes.push_back(8'($urandom));
        end else begin
            // frame cut short; whatever follows is parsed in its positional role
            push_frame(start_now, 8'($urandom), pick_len(), 1'b0, 8'h00, 1'b0);
            keep = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > keep)
                void'(frame_bytes.pop_back());
        end
        send_queue();
    endtask

    initial
    begin : stimulus
        logic [7:0] settings[NUM_SETTINGS];
        int         directed_bytes;

        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 8'h00;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        hold_req      = 1'b0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        bytes_sent    = 0;
        settings_used = 0;
        start_now     = START_BYTE_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle extremes, zero-length frame, start value inside a frame,
        // bad checksum, then a short clean frame typed with the start value
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        push_frame(start_now, 8'h00, 0, 1'b0, 8'h00, 1'b0);
        push_frame(start_now, 8'hFF, 2, 1'b1, start_now, 1'b1);
        push_frame(start_now, start_now, 1, 1'b1, 8'hFF, 1'b0);
        send_queue();
        directed_bytes = bytes_sent;

        // register extremes, 0x01, the reset value again and two random settings
        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = 8'($urandom);
        settings[3] = START_BYTE_RESET;
        settings[4] = 8'($urandom);
        settings[5] = 8'h01;

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            // on odd settings the write lands between the type and length bytes
            if (p % 2 == 1) begin
                frame_bytes.push_back(start_now);
                frame_bytes.push_back(8'($urandom));
                send_queue();
            end
            drain();
            write_start(settings[p]);

            if (p == 1) begin
                // long receiver hold-off while the sender keeps pushing
                hold_req  = 1'b1;
                tx_steady = 1'b1;
                push_frame(start_now, 8'($urandom), 30, 1'b0, 8'h00, 1'b0);
                send_queue();
                tx_steady = 1'b0;
            end
            if (p == 2) begin
                tx_steady = 1'b1;
                rx_steady = 1'b1;
            end
            if (p == 3) begin
                // the one longest payload of the run
                push_frame(start_now, 8'($urandom), 255, 1'b0, 8'h00, 1'b0);
                send_queue();
            end

            while (bytes_sent < directed_bytes + (p + 1) * RANDOM_BYTES / NUM_SETTINGS)
                random_chunk();

            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d bytes and %0d result beats over %0d start byte settings",
                 bytes_sent, sb.checked, settings_used + 1);
        $display("frames ended with good crc: %0d, with bad crc: %0d",
                 sb.frames_good, sb.frames_bad);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> crc32_packet_deframer.f
hdl/cpd_pkg.sv
hdl/cpd_crc_byte.sv
hdl/crc32_packet_deframer.sv
bench/tb.sv
